>>> hw/rtl/ssrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssrr_pkg;

    localparam int unsigned SIG_BITS = 12;

    typedef enum logic {
        OP_VICTIM = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [10:0] set_index;
        logic [3:0]  way;
        logic [63:0] address;
        logic [63:0] pc;
        logic        hit;
        logic [4:0]  chance;
    } t_req;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       streaming;
        logic [9:0] selector_value;
    } t_rsp;

    localparam logic [1:0] CFG_STREAM_THRESHOLD = 2'd0;
    localparam logic [2:0] THRESHOLD_RESET = 3'd4;

endpackage
`default_nettype wire

>>> hw/rtl/ssrr_stride.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-set stride detector; one synchronous memory row per set.
module ssrr_stride #(
    parameter int unsigned SETS = 2048,
    parameter int unsigned SET_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd,
    input  wire logic [SET_W-1:0] i_set,
    input  wire logic             i_wr,
    input  wire logic             i_clr,
    input  wire logic [SET_W-1:0] i_clr_set,
    input  wire logic [63:0]      i_addr,
    input  wire logic [2:0]       i_thr,
    output logic                  o_stream
);
    localparam int unsigned ROW_W = 64 + 64 + 3;

    logic [ROW_W-1:0] r_mem [SETS];
    logic [ROW_W-1:0] r_row;
    logic [63:0] prev_a, prev_s, stride;
    logic [2:0]  run, n_run;

    // The clearing pass after reset zeroes every row before the first read.
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_row    <= r_mem[i_set];
        end
        if (i_clr) begin
            r_mem[i_clr_set] <= '0;
        end else if (i_wr) begin
            r_mem[i_set] <= {i_addr, stride, n_run};
        end
    end

    always_comb begin
        prev_a = r_row[ROW_W-1 -: 64];
        prev_s = r_row[66:3];
        run    = r_row[2:0];
        stride = (prev_a == '0) ? '0 : i_addr - prev_a;
        n_run  = run;
        if (prev_s != '0) begin
            if (stride == prev_s) begin
                if (run < i_thr) begin
                    n_run = run + 3'd1;
                end
            end else begin
                n_run = '0;
            end
        end
        o_stream = n_run >= i_thr;
    end
endmodule
`default_nettype wire

>>> hw/rtl/ship_stream_rrip_replacement_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: at the accepting edge the set row and the new signature's reuse counter are read,
// the old signature's counter is read in READ, the state is written back in WRITE, and the
// result is registered in r_res and moved to the output register once that is free.
// No new request is taken until the previous result has entered the output register.
// Reset: synchronous, active low; a clearing pass over max(SETS, SIGNATURE_ENTRIES) entries
// (4096 by default) initializes the memories, and o_ready stays low until it ends.
module ship_stream_rrip_replacement_core #(
    parameter int unsigned SETS = 2048,
    parameter int unsigned WAYS = 16,
    parameter int unsigned SIGNATURE_ENTRIES = 4096,
    parameter int unsigned LEADER_COUNT = 64,
    parameter int unsigned DUEL_WIDTH = 10,
    parameter int unsigned AGE_WIDTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ssrr_pkg::t_req  i_req,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ssrr_pkg::t_rsp       o_rsp,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [1:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam int unsigned SET_W = $clog2(SETS);
    localparam int unsigned WAY_W = $clog2(WAYS);
    localparam int unsigned SIG_W = $clog2(SIGNATURE_ENTRIES);
    localparam int unsigned AGE_LSB = ssrr_pkg::SIG_BITS;
    localparam int unsigned LINE_W = AGE_WIDTH + ssrr_pkg::SIG_BITS;
    localparam int unsigned ROW_W = WAYS * LINE_W;
    localparam int unsigned CLR_N = (SETS > SIGNATURE_ENTRIES) ? SETS : SIGNATURE_ENTRIES;
    localparam int unsigned CLR_W = $clog2(CLR_N);
    localparam logic [AGE_WIDTH-1:0] MAX_AGE = '1;
    localparam logic [DUEL_WIDTH-1:0] DUEL_MAX = '1;
    localparam logic [DUEL_WIDTH-1:0] DUEL_RESET = DUEL_MAX >> 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_HOLD
    } t_state;

    // Line ages and signatures of a whole set live in one row; the reuse table
    // is a second memory. Both are initialized by the clearing pass.
    logic [ROW_W-1:0]  r_lines [SETS];
    logic [1:0]        r_reuse [SIGNATURE_ENTRIES];
    logic [ROW_W-1:0]  r_row;
    logic [1:0]        r_ru_new, r_ru_old;
    logic [CLR_W-1:0]  r_clr;
    t_state            r_state;
    ssrr_pkg::t_req    r_req;
    ssrr_pkg::t_rsp    r_res, r_rsp;
    logic              r_out_valid;
    logic [2:0]        r_thr;
    logic [DUEL_WIDTH-1:0] r_duel, n_duel;

    logic [SET_W-1:0]  set_in, set_q, clr_set;
    logic [WAY_W-1:0]  way_q;
    logic [SIG_W-1:0]  sig_in, sig_q, old_sig, clr_sig, ru_addr;
    logic [63:0]       pc_mix, pcq_mix;
    logic              stream, accept, cfg_wr, out_free;
    logic              clr_set_en, clr_sig_en, clr_done;
    logic [ROW_W-1:0]  n_row;
    logic [WAY_W-1:0]  victim;
    logic              found;
    logic [1:0]        ru_wdata;
    logic [AGE_WIDTH-1:0] ins_age;
    logic              lead_s, lead_b, upd;

    assign set_in  = i_req.set_index[SET_W-1:0];
    assign pc_mix  = i_req.pc ^ (i_req.pc >> 6);
    assign sig_in  = pc_mix[SIG_W-1:0];
    assign set_q   = r_req.set_index[SET_W-1:0];
    assign way_q   = r_req.way[WAY_W-1:0];
    assign pcq_mix = r_req.pc ^ (r_req.pc >> 6);
    assign sig_q   = pcq_mix[SIG_W-1:0];
    assign upd     = r_req.operation == ssrr_pkg::OP_UPDATE;

    // The clearing pass walks every set and every signature entry once.
    assign clr_set    = r_clr[SET_W-1:0];
    assign clr_sig    = r_clr[SIG_W-1:0];
    assign clr_set_en = {1'b0, r_clr} < (CLR_W+1)'(SETS);
    assign clr_sig_en = {1'b0, r_clr} < (CLR_W+1)'(SIGNATURE_ENTRIES);
    assign clr_done   = r_clr == CLR_W'(CLR_N - 1);

    assign accept   = i_valid && o_ready;
    assign o_ready  = r_state == ST_IDLE;
    assign out_free = !r_out_valid || i_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = {29'd0, r_thr};
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_rsp;

    ssrr_stride #(.SETS(SETS), .SET_W(SET_W)) u_stride (
        .i_clk    (i_clk),
        .i_rd     (accept),
        .i_set    (accept ? set_in : set_q),
        .i_wr     (r_state == ST_WRITE && upd),
        .i_clr    (r_state == ST_CLEAR && clr_set_en),
        .i_clr_set(clr_set),
        .i_addr   (r_req.address),
        .i_thr    (r_thr),
        .o_stream (stream)
    );

    // Memory ports: the row and the new signature's counter are read on accept,
    // the old signature's counter in the READ cycle, and the write back happens
    // in the WRITE cycle. One request is in flight at a time, so every write
    // lands before the next request reads.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row    <= r_lines[set_in];
            r_ru_new <= r_reuse[sig_in];
        end
        if (r_state == ST_READ) begin
            r_ru_old <= r_reuse[old_sig];
        end
        if (r_state == ST_CLEAR) begin
            if (clr_set_en) begin
                r_lines[clr_set] <= '0;
            end
            if (clr_sig_en) begin
                r_reuse[clr_sig] <= 2'd1;
            end
        end else if (r_state == ST_WRITE) begin
            r_lines[set_q] <= n_row;
            if (upd) begin
                r_reuse[ru_addr] <= ru_wdata;
            end
        end
    end

    always_comb begin
        old_sig = SIG_W'(r_row[way_q*LINE_W +: ssrr_pkg::SIG_BITS]);
        n_row = r_row;
        found = 1'b0;
        victim = '0;
        ins_age = '0;
        lead_s = set_q < SET_W'(LEADER_COUNT);
        lead_b = !lead_s && ({1'b0, set_q} + (SET_W+1)'(LEADER_COUNT) >= (SET_W+1)'(SETS));
        n_duel = r_duel;
        // A hit counts one reuse for the access signature; a fill charges the
        // line's old signature with one lost reuse. Both saturate.
        ru_addr = r_req.hit ? sig_q : old_sig;
        if (r_req.hit) begin
            ru_wdata = (r_ru_new < 2'd3) ? r_ru_new + 2'd1 : r_ru_new;
        end else begin
            ru_wdata = (r_ru_old > 2'd0) ? r_ru_old - 2'd1 : r_ru_old;
        end
        if (!upd) begin
            // Lowest way at maximum age wins; without one, every way ages once.
            // No age can overflow there, since none is at the maximum.
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (r_row[w*LINE_W+AGE_LSB +: AGE_WIDTH] == MAX_AGE) begin
                    found = 1'b1;
                    victim = WAY_W'(w);
                end
            end
            if (!found) begin
                for (int w = 0; w < WAYS; w++) begin
                    n_row[w*LINE_W+AGE_LSB +: AGE_WIDTH] =
                        r_row[w*LINE_W+AGE_LSB +: AGE_WIDTH] + 1'b1;
                end
                for (int w = WAYS - 1; w >= 0; w--) begin
                    if (n_row[w*LINE_W+AGE_LSB +: AGE_WIDTH] == MAX_AGE) begin
                        victim = WAY_W'(w);
                    end
                end
            end
        end else begin
            if (stream) ins_age = MAX_AGE;
            else ins_age = (r_ru_new >= 2'd2) ? '0 : MAX_AGE - 1'b1;
            if (lead_s) ins_age = MAX_AGE - 1'b1;
            else if (lead_b) ins_age = (r_req.chance == '0) ? MAX_AGE - 1'b1 : MAX_AGE;
            if (r_req.hit) begin
                n_row[way_q*LINE_W+AGE_LSB +: AGE_WIDTH] = '0;
            end else begin
                n_row[way_q*LINE_W+AGE_LSB +: AGE_WIDTH] = ins_age;
                n_row[way_q*LINE_W +: ssrr_pkg::SIG_BITS] = ssrr_pkg::SIG_BITS'(sig_q);
            end
            if ((lead_s && r_req.hit) || (lead_b && !r_req.hit)) begin
                if (r_duel < DUEL_MAX) n_duel = r_duel + 1'b1;
            end else if (lead_s || lead_b) begin
                if (r_duel > '0) n_duel = r_duel - 1'b1;
            end
        end
    end

    // The finished result waits in r_res until the output register is free, so
    // a stalled result never loses its payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= ssrr_pkg::THRESHOLD_RESET;
            r_duel      <= DUEL_RESET;
        end else begin
            if (cfg_wr && paddr == ssrr_pkg::CFG_STREAM_THRESHOLD) begin
                r_thr <= pwdata[2:0];
            end
            if (r_state == ST_HOLD && out_free) begin
                r_out_valid <= 1'b1;
                r_rsp       <= r_res;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (clr_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_req   <= i_req;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_duel <= n_duel;
                    r_res.victim_way <= upd ? 4'd0 : 4'(victim);
                    r_res.streaming  <= upd && stream;
                    r_res.selector_value <= 10'(n_duel);
                    r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready) else $error("request accepted while busy");
    a_duel_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && !upd) |=> $stable(r_duel)) else $error("victim moved duel");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)))
        else $error("result dropped or changed while waiting");
`endif
endmodule
`default_nettype wire
